@@ rtl/mvm_pkg.sv @@
// shared types and constants of the matrix-vector engine
package mvm_pkg;

   localparam int MAX_ROWS_DEF    = 64;
   localparam int MAX_COLUMNS_DEF = 256;

   localparam int VALUE_W  = 16;
   localparam int ACC_W    = 48;
   localparam int RESULT_W = 32;
   localparam int ROW_W    = 6;

   // item opcodes
   localparam logic OP_WEIGHT = 1'b0;
   localparam logic OP_VECTOR = 1'b1;

   // register indexes, byte address over four
   localparam int REG_ROWS    = 0;
   localparam int REG_COLUMNS = 1;

   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctrl_type;

endpackage

@@ rtl/matrix_vector_multiply.sv @@
// top level of the weight-stationary matrix-vector engine
//
//   channel   ports                                   handshake
//   input     req_op, req_value                       start high while busy low
//   result    rsp_row_index, rsp_result_value,        rsp_valid, one cycle,
//             rsp_last                                no back-pressure
//   config    psel, penable, pwrite, paddr, pwdata,   apb write in access phase,
//             prdata, pready                          pready tied high
//
// a weight item is written to the weight ram at accept
// a vector item sweeps all MAX_ROWS rows: the single shared multiplier and
// the one ram read port visit every row once, behind the ram read and product registers
// the last element of a token adds a drain of the ring that emits the results
// reset is synchronous; it clears control state and the accumulator ring,
// the weight ram keeps whatever it holds
// results cannot be stalled, so nothing inside ever waits on the receiver
module matrix_vector_multiply #(
   parameter int MAX_ROWS    = mvm_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLUMNS = mvm_pkg::MAX_COLUMNS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // input channel
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_op,
   input  logic signed [mvm_pkg::VALUE_W-1:0]  req_value,
   // result channel
   output logic                                rsp_valid,
   output logic [mvm_pkg::ROW_W-1:0]           rsp_row_index,
   output logic signed [mvm_pkg::RESULT_W-1:0] rsp_result_value,
   output logic                                rsp_last,
   // configuration port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [2:0]                          paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   // sizes
   localparam int DEPTH  = MAX_ROWS * MAX_COLUMNS;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int TW     = $clog2(DEPTH + 1);
   localparam int ERW    = $clog2(MAX_ROWS + 1);
   localparam int ECW    = $clog2(MAX_COLUMNS + 1);
   localparam int ACC_W  = mvm_pkg::ACC_W;
   localparam int VAL_W  = mvm_pkg::VALUE_W;
   localparam int RES_W  = mvm_pkg::RESULT_W;
   localparam int ROW_W  = mvm_pkg::ROW_W;

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MAC  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   // q24.24 accumulator to q16.16: round half up, floor, saturate
   function automatic logic signed [RES_W-1:0] to_q16(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W:0]   rounded;
      logic signed [ACC_W-8:0] q;
      logic signed [RES_W-1:0] res;
      rounded = {acc[ACC_W-1], acc} + (ACC_W+1)'(128);
      q       = rounded[ACC_W:8];
      if (q > (ACC_W-7)'(64'sd2147483647)) begin
         res = 32'sh7FFF_FFFF;
      end else if (q < -(ACC_W-7)'(64'sd2147483648)) begin
         res = 32'sh8000_0000;
      end else begin
         res = q[RES_W-1:0];
      end
      return res;
   endfunction

   // configuration registers
   logic [6:0] rows_ff, rows_in;
   logic [8:0] cols_ff, cols_in;

   // sequencer and pointers
   logic [1:0]     state_ff, state_in;
   logic [AW-1:0]  wp_ff, wp_in;
   logic [ECW-1:0] ec_ff, ec_in;
   logic           last_tok_ff, last_tok_in;
   logic [AW-1:0]  rd_addr_ff, rd_addr_in;
   logic [ERW-1:0] issue_cnt_ff, issue_cnt_in;
   logic [ERW-1:0] step_cnt_ff, step_cnt_in;
   logic signed [VAL_W-1:0] x_ff, x_in;

   // multiply pipeline
   logic                    s1_v_ff, s1_use_ff;
   logic                    s2_v_ff, s2_use_ff;
   logic signed [RES_W-1:0] prod_ff, prod_in;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]        rsp_row_ff, rsp_row_in;
   logic signed [RES_W-1:0] rsp_value_ff, rsp_value_in;
   logic                    rsp_last_ff, rsp_last_in;

   // ring and ram hookup
   mvm_pkg::cell_ctrl_type  ring_ctrl;
   logic signed [ACC_W-1:0] ring_acc [MAX_ROWS];
   logic signed [ACC_W-1:0] tail;
   logic signed [ACC_W-1:0] head;
   logic                    ram_we;
   logic                    ram_re;
   logic [VAL_W-1:0]        ram_rdata;

   logic                    cfg_write;
   logic                    issuing;
   logic [ERW-1:0]          eff_rows;
   logic [ECW-1:0]          eff_cols;
   logic [TW-1:0]           total;

   // effective sizes: zero counts as one, large values saturate
   always_comb begin
      if (rows_ff == '0) begin
         eff_rows = ERW'(1);
      end else if (int'(rows_ff) > MAX_ROWS) begin
         eff_rows = ERW'(MAX_ROWS);
      end else begin
         eff_rows = ERW'(rows_ff);
      end
      if (cols_ff == '0) begin
         eff_cols = ECW'(1);
      end else if (int'(cols_ff) > MAX_COLUMNS) begin
         eff_cols = ECW'(MAX_COLUMNS);
      end else begin
         eff_cols = ECW'(cols_ff);
      end
   end

   // matrix size, for the weight pointer wrap
   assign total = TW'(eff_rows) * TW'(eff_cols);

   assign cfg_write = psel && penable && pwrite;
   assign issuing   = (state_ff == ST_MAC) && (issue_cnt_ff != ERW'(MAX_ROWS));
   assign head      = ring_acc[0];
   assign ram_re    = issuing;

   // product of the weight just read and the held vector element
   assign prod_in = $signed(ram_rdata) * x_ff;

   always_comb begin
      rows_in      = rows_ff;
      cols_in      = cols_ff;
      state_in     = state_ff;
      wp_in        = wp_ff;
      ec_in        = ec_ff;
      last_tok_in  = last_tok_ff;
      rd_addr_in   = rd_addr_ff;
      issue_cnt_in = issue_cnt_ff;
      step_cnt_in  = step_cnt_ff;
      x_in         = x_ff;
      rsp_valid_in = 1'b0;
      rsp_row_in   = rsp_row_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      ram_we       = 1'b0;
      ring_ctrl    = '0;
      tail         = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_op == mvm_pkg::OP_WEIGHT) begin
                  // weight item: store and advance, wrapping after the last entry
                  ram_we = 1'b1;
                  if ((TW'(wp_ff) + TW'(1)) >= total) begin
                     wp_in = '0;
                  end else begin
                     wp_in = wp_ff + AW'(1);
                  end
               end else begin
                  // vector item: sweep all rows starting at this column
                  x_in         = req_value;
                  rd_addr_in   = AW'(ec_ff);
                  issue_cnt_in = '0;
                  step_cnt_in  = '0;
                  last_tok_in  = ((ec_ff + ECW'(1)) == eff_cols);
                  ec_in        = last_tok_in ? '0 : (ec_ff + ECW'(1));
                  state_in     = ST_MAC;
               end
            end
         end
         ST_MAC: begin
            if (issuing) begin
               rd_addr_in   = rd_addr_ff + AW'(eff_cols);
               issue_cnt_in = issue_cnt_ff + ERW'(1);
            end
            // head of the ring is the row whose product arrives now
            if (s2_v_ff) begin
               ring_ctrl.shift = 1'b1;
               tail = s2_use_ff ? (head + ACC_W'(prod_ff)) : head;
               step_cnt_in = step_cnt_ff + ERW'(1);
               if (step_cnt_ff == ERW'(MAX_ROWS - 1)) begin
                  step_cnt_in = '0;
                  state_in    = last_tok_ff ? ST_EMIT : ST_IDLE;
               end
            end
         end
         ST_EMIT: begin
            // drain the ring one row a cycle, zeros refill from the tail
            ring_ctrl.shift = 1'b1;
            if (step_cnt_ff < eff_rows) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = ROW_W'(step_cnt_ff);
               rsp_value_in = to_q16(head);
               rsp_last_in  = (step_cnt_ff == (eff_rows - ERW'(1)));
            end
            step_cnt_in = step_cnt_ff + ERW'(1);
            if (step_cnt_ff == ERW'(MAX_ROWS - 1)) begin
               step_cnt_in = '0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // any register write rewinds the weight and column pointers and clears the ring, weights are kept
      if (cfg_write) begin
         if (paddr[2] == 1'(mvm_pkg::REG_ROWS)) begin
            rows_in = pwdata[6:0];
         end else begin
            cols_in = pwdata[8:0];
         end
         wp_in           = '0;
         ec_in           = '0;
         ring_ctrl.clear = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff      <= 7'(MAX_ROWS);
         cols_ff      <= 9'(MAX_COLUMNS);
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         ec_ff        <= '0;
         last_tok_ff  <= 1'b0;
         issue_cnt_ff <= '0;
         step_cnt_ff  <= '0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         ec_ff        <= ec_in;
         last_tok_ff  <= last_tok_in;
         issue_cnt_ff <= issue_cnt_in;
         step_cnt_ff  <= step_cnt_in;
         s1_v_ff      <= issuing;
         s2_v_ff      <= s1_v_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_addr_ff   <= rd_addr_in;
      x_ff         <= x_in;
      s1_use_ff    <= (issue_cnt_ff < eff_rows);
      s2_use_ff    <= s1_use_ff;
      prod_ff      <= prod_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // weight store, row-major over the current matrix shape
   mvm_ram #(
      .WIDTH (VAL_W),
      .DEPTH (DEPTH)
   ) u_weight_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wp_ff),
      .wr_data (req_value),
      .rd_en   (ram_re),
      .rd_addr (rd_addr_ff),
      .rd_data (ram_rdata)
   );

   // accumulator ring: cell k takes from cell k+1, the last cell from the tail
   for (genvar k = 0; k < MAX_ROWS; k++) begin : g_ring
      logic signed [ACC_W-1:0] cell_din;
      if (k == MAX_ROWS - 1) begin : g_tail
         assign cell_din = tail;
      end else begin : g_link
         assign cell_din = ring_acc[k+1];
      end
      mvm_cell u_cell (
         .clock (clock),
         .reset (reset),
         .ctrl  (ring_ctrl),
         .din   (cell_din),
         .dout  (ring_acc[k])
      );
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_row_index    = rsp_row_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_last         = rsp_last_ff;
   assign pready           = 1'b1;
   assign prdata           = (paddr[2] == 1'(mvm_pkg::REG_COLUMNS)) ? 32'(cols_ff)
                                                                    : 32'(rows_ff);

   // results only come out of a drain that the sequencer was running
   a_rsp_from_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_EMIT))
      else $error("result strobe outside of a drain");

   // products only reach the ring while the sequencer is in the mac phase
   a_prod_in_mac: assert property (@(posedge clock) disable iff (reset)
      s2_v_ff |-> (state_ff == ST_MAC))
      else $error("product arrived outside the mac phase");

   // the final result of a token belongs to the last row in use
   a_last_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> (ERW'(rsp_row_index) == eff_rows - ERW'(1)))
      else $error("last flag on a row that is not the final one");

   // weight pointer stays inside the matrix
   a_wp_range: assert property (@(posedge clock) disable iff (reset)
      TW'(wp_ff) < total)
      else $error("weight pointer beyond matrix size");

   // column counter stays inside the token
   a_ec_range: assert property (@(posedge clock) disable iff (reset)
      ec_ff < eff_cols)
      else $error("element counter beyond token width");

endmodule

@@ rtl/mvm_ram.sv @@
// generic simple dual-port ram with registered read
module mvm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/mvm_cell.sv @@
// one accumulator cell of the rotating accumulator ring
module mvm_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  mvm_pkg::cell_ctrl_type           ctrl,
   input  logic signed [mvm_pkg::ACC_W-1:0] din,
   output logic signed [mvm_pkg::ACC_W-1:0] dout
);

   logic signed [mvm_pkg::ACC_W-1:0] acc_ff;

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         acc_ff <= '0;
      end else if (ctrl.shift) begin
         acc_ff <= din;
      end
   end

   assign dout = acc_ff;

endmodule
